[rtl/core/olist_pkg.sv]
// Package for the ordered list engine: command and status codes,
// the cell operation type and the control bundle broadcast along the cell chain.
// No dependencies.
package olist_pkg;

    // Fixed widths of the transaction fields.
    localparam int CMD_W   = 4;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 7;
    // Cell index width, sized for the largest supported capacity.
    localparam int IDX_W   = 6;
    localparam int CAPACITY_DEFAULT = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_AT   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REVERSE  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_PRINT    = 4'd9;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Operation applied by all cells in the same cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    idx;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

endpackage

[rtl/core/olist_cell.sv]
// One storage cell of the list chain: holds one element and moves data
// to and from its neighbors. Depends on olist_pkg.
module olist_cell #(
    parameter int INDEX = 0
) (
    input  logic                       aclk,
    input  olist_pkg::cell_ctrl_t      ctrl,
    input  logic [olist_pkg::DATA_W-1:0] left_i,
    input  logic [olist_pkg::DATA_W-1:0] right_i,
    input  logic [olist_pkg::DATA_W-1:0] head_i,
    output logic [olist_pkg::DATA_W-1:0] data_o
);
    import olist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Insert shifts later cells back, delete pulls them forward, and
    // rotate moves the head to the cell at idx while the cells before it advance.
    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (MY_IDX > ctrl.idx) begin
                    data_next = left_i;
                end else if (MY_IDX == ctrl.idx) begin
                    data_next = ctrl.value;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= ctrl.idx) begin
                    data_next = right_i;
                end
            end
            CELL_ROT: begin
                if (MY_IDX < ctrl.idx) begin
                    data_next = right_i;
                end else if (MY_IDX == ctrl.idx) begin
                    data_next = head_i;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule

[rtl/core/olist_chain.sv]
// Row of CAPACITY list cells with neighbor links; cell 0 is the list head.
// Depends on olist_pkg and olist_cell.
module olist_chain #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEFAULT
) (
    input  logic                         aclk,
    input  olist_pkg::cell_ctrl_t        ctrl,
    output logic [olist_pkg::DATA_W-1:0] head_o
);
    import olist_pkg::*;

    logic [DATA_W-1:0] cell_data [CAPACITY];

    // Each cell sees its neighbors; the ends see their own data.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = cell_data[i];
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_end
            assign right_w = cell_data[i];
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end
        olist_cell #(.INDEX(i)) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .left_i  (left_w),
            .right_i (right_w),
            .head_i  (cell_data[0]),
            .data_o  (cell_data[i])
        );
    end

    assign head_o = cell_data[0];

endmodule

[rtl/core/ordered_list_engine.sv]
// Top level of the ordered list engine: command sequencer, length counter
// and output register around the cell chain. Depends on olist_pkg and olist_chain.
//
//   channel   direction  ports                                          handshake
//   command   in         s_cmd, s_value, s_position                      s_valid / s_ready
//   result    out        m_status, m_found_position, m_list_length,      m_valid / m_ready
//                        m_element, m_last
//
// Inserts, deletes, clear and unused codes are done when accepted, with no walk.
// Search and print rotate the list through the head cell, one element per cycle
// while the result register is free or being read; reverse stops one element short.
// aresetn empties the list; element contents are not cleared.
// A stalled result holds the sequencer; a new command is taken once the
// previous one is finished and the result register is free or being read.
module ordered_list_engine #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [olist_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [olist_pkg::DATA_W-1:0] s_value,
    input  logic [olist_pkg::POS_W-1:0]    s_position,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [olist_pkg::STAT_W-1:0]   m_status,
    output logic [olist_pkg::CNT_W-1:0]    m_found_position,
    output logic [olist_pkg::CNT_W-1:0]    m_list_length,
    output logic signed [olist_pkg::DATA_W-1:0] m_element,
    output logic                           m_last
);
    import olist_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic {
        IDLE,
        WALK
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   found_reg, found_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [CNT_W-1:0]   fpos_reg, fpos_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [DATA_W-1:0]  elem_reg, elem_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    logic [DATA_W-1:0]  head;
    logic               out_free;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   f_w;
    logic [POS_W-1:0]   count_pos;

    olist_chain #(.CAPACITY(CAPACITY)) u_chain (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .head_o (head)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == IDLE) && out_free;
    assign cnt_m1    = count_reg - 7'd1;
    assign count_pos = POS_W'(count_reg);

    // Command decode and walk sequencing.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        k_next       = k_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        fpos_next    = fpos_reg;
        len_next     = len_reg;
        elem_next    = elem_reg;
        last_next    = last_reg;
        ctrl.op      = CELL_HOLD;
        ctrl.idx     = '0;
        ctrl.value   = s_value;
        f_w          = found_reg;

        unique case (state_reg)
            IDLE: begin
                if (s_valid && s_ready) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_OK;
                    fpos_next    = '0;
                    elem_next    = '0;
                    last_next    = 1'b1;
                    cmd_next     = s_cmd;
                    val_next     = s_value;
                    k_next       = '0;
                    found_next   = '0;
                    case (s_cmd)
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                            if (count_reg >= CAP_CNT) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.op    = CELL_INS;
                                count_next = count_reg + 7'd1;
                                if (s_cmd == CMD_INS_HEAD) begin
                                    ctrl.idx = '0;
                                end else if (s_cmd == CMD_INS_TAIL) begin
                                    ctrl.idx = IDX_W'(count_reg);
                                end else if (s_position <= 8'd1) begin
                                    ctrl.idx = '0;
                                end else if (s_position > count_pos) begin
                                    ctrl.idx = IDX_W'(count_reg);
                                end else begin
                                    ctrl.idx = IDX_W'(s_position - 8'd1);
                                end
                            end
                        end
                        CMD_DEL_HEAD: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ctrl.op    = CELL_DEL;
                                ctrl.idx   = '0;
                                count_next = cnt_m1;
                            end
                        end
                        CMD_DEL_TAIL: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = cnt_m1;
                            end
                        end
                        CMD_DEL_AT: begin
                            if (s_position == '0 || s_position > count_pos) begin
                                status_next = ST_BADPOS;
                            end else begin
                                ctrl.op    = CELL_DEL;
                                ctrl.idx   = IDX_W'(s_position - 8'd1);
                                count_next = cnt_m1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOTFOUND;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = WALK;
                            end
                        end
                        CMD_REVERSE: begin
                            if (count_reg >= 7'd2) begin
                                m_valid_next = 1'b0;
                                state_next   = WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_PRINT: begin
                            if (count_reg != '0) begin
                                m_valid_next = 1'b0;
                                state_next   = WALK;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                    len_next = count_next;
                end
            end
            WALK: begin
                if (out_free) begin
                    ctrl.op  = CELL_ROT;
                    ctrl.idx = IDX_W'(cnt_m1);
                    k_next   = k_reg + 7'd1;
                    len_next = count_reg;
                    case (cmd_reg)
                        CMD_SEARCH: begin
                            if (found_reg == '0 && head == val_reg) begin
                                f_w = k_reg + 7'd1;
                            end
                            found_next = f_w;
                            if (k_reg == cnt_m1) begin
                                m_valid_next = 1'b1;
                                status_next  = (f_w != '0) ? ST_OK : ST_NOTFOUND;
                                fpos_next    = f_w;
                                elem_next    = '0;
                                last_next    = 1'b1;
                                state_next   = IDLE;
                            end
                        end
                        CMD_PRINT: begin
                            m_valid_next = 1'b1;
                            status_next  = ST_OK;
                            fpos_next    = '0;
                            elem_next    = head;
                            last_next    = (k_reg == cnt_m1);
                            if (k_reg == cnt_m1) begin
                                state_next = IDLE;
                            end
                        end
                        default: begin
                            // Reverse: move the head behind the unreversed part.
                            ctrl.idx = IDX_W'(cnt_m1 - k_reg);
                            if (k_reg == count_reg - 7'd2) begin
                                m_valid_next = 1'b1;
                                status_next  = ST_OK;
                                fpos_next    = '0;
                                elem_next    = '0;
                                last_next    = 1'b1;
                                state_next   = IDLE;
                            end
                        end
                    endcase
                end
            end
            default: state_next = IDLE;
        endcase
    end

    // Control state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        fpos_reg   <= fpos_next;
        len_reg    <= len_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_found_position = fpos_reg;
    assign m_list_length    = len_reg;
    assign m_element        = elem_reg;
    assign m_last           = last_reg;

endmodule

[tb/sv/ordered_list_checker.sv]
// Checker for the ordered list engine: watches both channels, keeps its own copy
// of the list, predicts every result and compares. Depends on olist_pkg.
module ordered_list_checker #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [olist_pkg::CMD_W-1:0]         s_cmd,
    input  logic signed [olist_pkg::DATA_W-1:0] s_value,
    input  logic [olist_pkg::POS_W-1:0]         s_position,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [olist_pkg::STAT_W-1:0]        m_status,
    input  logic [olist_pkg::CNT_W-1:0]         m_found_position,
    input  logic [olist_pkg::CNT_W-1:0]         m_list_length,
    input  logic signed [olist_pkg::DATA_W-1:0] m_element,
    input  logic                                m_last,
    output int                                  fail_count,
    output int                                  pending_results
);
    import olist_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         found;
        logic [CNT_W-1:0]         length;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } list_result_t;

    logic signed [DATA_W-1:0] shadow_list[CAPACITY];
    int                       shadow_count;
    list_result_t             expected_results[$];

    assign pending_results = expected_results.size();

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic list_result_t make_result(logic [STAT_W-1:0] st,
                                                 int found, logic signed [DATA_W-1:0] el,
                                                 logic lst);
        list_result_t r;
        r.status = st;
        r.found = found[CNT_W-1:0];
        r.length = shadow_count[CNT_W-1:0];
        r.element = el;
        r.last = lst;
        return r;
    endfunction

    function automatic logic [STAT_W-1:0] list_insert(int idx, logic signed [DATA_W-1:0] v);
        if (shadow_count >= CAPACITY) return ST_FULL;
        if (idx > shadow_count) idx = shadow_count;
        for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[idx] = v;
        shadow_count++;
        return ST_OK;
    endfunction

    function automatic void list_remove(int idx);
        for (int i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
        shadow_count--;
    endfunction

    // Applies one command to the shadow list and queues its results.
    function automatic void apply_command(logic [CMD_W-1:0] cmd,
                                          logic signed [DATA_W-1:0] v, int pos);
        logic [STAT_W-1:0]        st;
        int                       found;
        logic signed [DATA_W-1:0] t;
        st = ST_OK;
        found = 0;
        case (cmd)
            CMD_INS_HEAD: st = list_insert(0, v);
            CMD_INS_TAIL: st = list_insert(shadow_count, v);
            CMD_INS_AT: begin
                if (pos <= 1) st = list_insert(0, v);
                else st = list_insert(pos - 1, v);
            end
            CMD_DEL_HEAD: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else list_remove(0);
            end
            CMD_DEL_TAIL: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else shadow_count--;
            end
            CMD_DEL_AT: begin
                if (pos < 1 || pos > shadow_count) st = ST_BADPOS;
                else list_remove(pos - 1);
            end
            CMD_SEARCH: begin
                st = ST_NOTFOUND;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_list[i] == v) begin
                        st = ST_OK;
                        found = i + 1;
                        break;
                    end
                end
            end
            CMD_REVERSE: begin
                for (int i = 0; i < shadow_count / 2; i++) begin
                    t = shadow_list[i];
                    shadow_list[i] = shadow_list[shadow_count-1-i];
                    shadow_list[shadow_count-1-i] = t;
                end
            end
            CMD_CLEAR: shadow_count = 0;
            CMD_PRINT: begin
                if (shadow_count > 0) begin
                    for (int i = 0; i < shadow_count; i++)
                        expected_results.push_back(make_result(ST_OK, 0, shadow_list[i],
                                                               i + 1 == shadow_count));
                    return;
                end
            end
            default: ;
        endcase
        expected_results.push_back(make_result(st, found, '0, 1'b1));
    endfunction

    // Predict on each accepted command; compare each accepted result.
    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) apply_command(s_cmd, s_value, int'(s_position));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                    if (m_found_position !== want.found)
                        report_mismatch($sformatf("found_position %0d, want %0d",
                                                  m_found_position, want.found));
                    if (m_list_length !== want.length)
                        report_mismatch($sformatf("list_length %0d, want %0d",
                                                  m_list_length, want.length));
                    if (m_element !== want.element)
                        report_mismatch($sformatf("element %0d, want %0d",
                                                  m_element, want.element));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
                end
            end
        end
    end

endmodule

[tb/sv/ordered_list_engine_tb.sv]
// Top of the ordered list engine testbench: clock, reset, command stimulus,
// result-side stalls and the verdict. Depends on olist_pkg, the engine and the checker.
module ordered_list_engine_tb;
    import olist_pkg::*;

    localparam int CAP = CAPACITY_DEFAULT;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic [POS_W-1:0]         s_position = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic [CNT_W-1:0]         m_found_position;
    logic [CNT_W-1:0]         m_list_length;
    logic signed [DATA_W-1:0] m_element;
    logic                     m_last;
    int                       fail_count;
    int                       pending_results;

    // Idle rates in percent and the long receiver hold-off request.
    int  send_idle_pct = 33;
    int  recv_idle_pct = 88;
    bit  hold_receiver = 1'b0;
    // Recently inserted values, reused so searches hit.
    logic signed [DATA_W-1:0] recent_values[$];

    always #1 aclk = ~aclk;

    ordered_list_engine #(.CAPACITY(CAP)) dut (.*);

    ordered_list_checker #(.CAPACITY(CAP)) result_checker (.*);

    // Receiver: random stalls, plus a long counted hold-off on request.
    initial begin
        int held;
        forever begin
            @(posedge aclk);
            if (hold_receiver) begin
                m_ready <= 1'b0;
                for (held = 0; held < 400; held++) @(posedge aclk);
                hold_receiver = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one command transaction and waits until it is accepted.
    // Valid stays high after acceptance; a drain lowers it, the next call only when it idles.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] v,
                                logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= v;
        s_position <= pos;
        if (cmd <= CMD_INS_AT) recent_values.push_back(v);
        if (recent_values.size() > 16) void'(recent_values.pop_front());
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
    endtask

    // Random command weighted toward list growth, with small positions.
    task automatic send_random();
        int                       pick;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         pos;
        pick = $urandom_range(99);
        v = $urandom();
        if (recent_values.size() > 0 && $urandom_range(1))
            v = recent_values[$urandom_range(recent_values.size() - 1)];
        pos = ($urandom_range(9) == 0) ? POS_W'($urandom()) : POS_W'($urandom_range(70));
        if (pick < 15)       send_command(CMD_INS_HEAD, v, pos);
        else if (pick < 30)  send_command(CMD_INS_TAIL, v, pos);
        else if (pick < 45)  send_command(CMD_INS_AT, v, pos);
        else if (pick < 51)  send_command(CMD_DEL_HEAD, v, pos);
        else if (pick < 57)  send_command(CMD_DEL_TAIL, v, pos);
        else if (pick < 65)  send_command(CMD_DEL_AT, v, pos);
        else if (pick < 80)  send_command(CMD_SEARCH, v, pos);
        else if (pick < 86)  send_command(CMD_REVERSE, v, pos);
        else if (pick < 88)  send_command(CMD_CLEAR, v, pos);
        else if (pick < 97)  send_command(CMD_PRINT, v, pos);
        else                 send_command(CMD_W'($urandom_range(15, 10)), v, pos);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-list cases, then extremes of every field.
        send_command(CMD_DEL_HEAD, 0, 8'd0);
        send_command(CMD_DEL_TAIL, 0, 8'd0);
        send_command(CMD_DEL_AT, 0, 8'd1);
        send_command(CMD_SEARCH, 0, 8'd0);
        send_command(CMD_REVERSE, 0, 8'd0);
        send_command(CMD_CLEAR, 0, 8'd0);
        send_command(CMD_PRINT, 0, 8'd0);
        send_command(CMD_INS_HEAD, 32'sh8000_0000, 8'hFF);
        send_command(CMD_INS_TAIL, 32'sh7FFF_FFFF, 8'h00);
        send_command(CMD_INS_AT, -1, 8'd0);
        send_command(CMD_INS_AT, 5, 8'd1);
        send_command(CMD_INS_AT, 6, 8'd3);
        send_command(CMD_INS_AT, 7, 8'd255);
        send_command(CMD_SEARCH, 7, 8'd0);
        send_command(CMD_SEARCH, 12345, 8'd0);
        send_command(CMD_PRINT, 0, 8'd0);
        send_command(CMD_REVERSE, 0, 8'd0);
        send_command(CMD_PRINT, 0, 8'd0);
        send_command(CMD_DEL_AT, 0, 8'd0);
        send_command(CMD_DEL_AT, 0, 8'd255);
        send_command(CMD_DEL_AT, 0, 8'd2);
        send_command(4'd15, 0, 8'd0);
        send_command(4'd10, 0, 8'd0);

        // Fill to capacity, overflow once, search, print the full list and clear it.
        send_idle_pct = 0;
        while (result_checker.shadow_count < CAP) send_command(CMD_INS_TAIL, $urandom(), 8'd0);
        send_command(CMD_INS_AT, 1, 8'd2);
        send_command(CMD_SEARCH, recent_values[$], 8'd0);
        send_command(CMD_PRINT, 0, 8'd0);
        send_command(CMD_CLEAR, 0, 8'd0);
        send_idle_pct = 33;

        // Random phases with different idle mixes; pauses and a long hold-off.
        for (int n = 0; n < 360; n++) begin
            if (n == 120) begin
                send_idle_pct = 88;
                recv_idle_pct = 33;
            end
            if (n == 240) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 160) hold_receiver = 1'b1;
            if (n == 80 || n == 280) drain_results();
            send_random();
        end

        drain_results();
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/core/olist_pkg.sv
rtl/core/olist_cell.sv
rtl/core/olist_chain.sv
rtl/core/ordered_list_engine.sv
tb/sv/ordered_list_checker.sv
tb/sv/ordered_list_engine_tb.sv
